// ----- sv/simon_pkg.sv -----
// ---------------------------------------------------------------------------
// simon_pkg
// Shared types, constants and round functions for the SIMON-64/128 engine.
// ---------------------------------------------------------------------------
package simon_pkg;

    localparam int ROUND_COUNT = 44;
    localparam int SEED_WORDS  = 4;
    localparam int RND_W       = $clog2(ROUND_COUNT);
    localparam logic [63:0] Z3_BITS     = 64'hfc2ce51207a635db;
    localparam logic [31:0] SCHED_CONST = 32'hfffffffc;

    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_KEY_LO  = 2'd1;
    localparam logic [1:0] REG_KEY_HI  = 2'd2;
    localparam logic [1:0] REG_CTR     = 2'd3;

    localparam logic [1:0] MODE_ENC   = 2'd0;
    localparam logic [1:0] MODE_DEC   = 2'd1;
    localparam logic [1:0] MODE_CTR   = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_KEYS = 4'b0010,
        ST_RUN  = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
        logic dir;
    } t_ks_ctl;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
        rotl32 = (v << s) | (v >> (32 - s));
    endfunction

    function automatic logic [31:0] rotr32(input logic [31:0] v, input int s);
        rotr32 = (v >> s) | (v << (32 - s));
    endfunction

    function automatic logic [31:0] mix(input logic [31:0] x);
        mix = (rotl32(x, 1) & rotl32(x, 8)) ^ rotl32(x, 2);
    endfunction

endpackage

// ----- sv/simon_key_cell.sv -----
// ---------------------------------------------------------------------------
// simon_key_cell
// One round-key cell; shifts to either neighbor or loads a new word.
// ---------------------------------------------------------------------------
module simon_key_cell (
    input  logic              i_clk,
    input  simon_pkg::t_ks_ctl i_ctl,
    input  logic [31:0]       i_load,
    input  logic [31:0]       i_prev,
    input  logic [31:0]       i_next,
    output logic [31:0]       o_key
);
    import simon_pkg::*;

    logic [31:0] r_key;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_key <= i_load;
        end else if (i_ctl.shift) begin
            r_key <= i_ctl.dir ? i_next : i_prev;
        end
    end

    assign o_key = r_key;
endmodule

// ----- sv/simon_key_chain.sv -----
// ---------------------------------------------------------------------------
// simon_key_chain
// Ring of key cells. Forward rotation presents keys 0,1,...; backward
// rotation presents keys N-1,N-2,... Expansion feeds generated words in.
// ---------------------------------------------------------------------------
module simon_key_chain (
    input  logic               i_clk,
    input  simon_pkg::t_ks_ctl i_ctl,
    input  logic               i_gen,
    input  logic [31:0]        i_gen_word,
    output logic [31:0]        o_head,
    output logic [31:0]        o_tail
);
    import simon_pkg::*;

    logic [31:0] w_key [ROUND_COUNT];
    t_ks_ctl     w_ctl;

    assign w_ctl = '{load: 1'b0, shift: i_ctl.shift | i_gen, dir: i_ctl.dir & ~i_gen};

    genvar g;
    generate
        for (g = 0; g < ROUND_COUNT; g++) begin : g_cell
            if (g == ROUND_COUNT - 1) begin : g_last
                t_ks_ctl w_lc;
                assign w_lc = '{load: i_gen, shift: w_ctl.shift, dir: w_ctl.dir};
                simon_key_cell u_cell (
                    .i_clk  (i_clk),
                    .i_ctl  (w_lc),
                    .i_load (i_gen_word),
                    .i_prev (w_key[0]),
                    .i_next (w_key[g-1]),
                    .o_key  (w_key[g])
                );
            end else begin : g_mid
                simon_key_cell u_cell (
                    .i_clk  (i_clk),
                    .i_ctl  (w_ctl),
                    .i_load (i_gen_word),
                    .i_prev (w_key[g+1]),
                    .i_next ((g == 0) ? w_key[ROUND_COUNT-1] : w_key[(g == 0) ? 0 : g-1]),
                    .o_key  (w_key[g])
                );
            end
        end
    endgenerate

    assign o_head = w_key[0];
    assign o_tail = w_key[ROUND_COUNT-1];
endmodule

// ----- sv/simon64_128_block_cipher_modes.sv -----
// ---------------------------------------------------------------------------
// simon64_128_block_cipher_modes
// SIMON-64/128 engine with ECB encrypt, ECB decrypt and counter mode.
// ---------------------------------------------------------------------------
// A block is accepted only while the engine is idle. Its result is computed
// one round per cycle, the round key taken from the head (in decrypt the
// tail) of a ring of 44 key cells that rotates each round; decrypt first
// adds an alignment step before the ring turns the other way. A new block
// is taken only after the result has been accepted on the output side.
// After reset or a key write the first block also waits for key expansion,
// one new key word per cycle shifted into the ring.
// ---------------------------------------------------------------------------
module simon64_128_block_cipher_modes (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_data_in,
    input  logic [3:0]  i_valid_bytes,
    input  logic        i_restart,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_data_out,
    output logic [3:0]  o_valid_bytes_out
);
    import simon_pkg::*;

    t_state      r_state, n_state;
    logic [1:0]  r_mode;
    logic [63:0] r_key_lo, r_key_hi, r_ictr, r_ctr;
    logic        r_keys_ready;
    logic [RND_W:0] r_cnt;
    logic [31:0] r_x, r_y;
    logic [63:0] r_din;
    logic [3:0]  r_vb;
    logic [1:0]  r_imode;
    logic        r_align;
    logic [31:0] r_w1, r_w2, r_w3;
    logic [63:0] r_out;

    t_ks_ctl     w_ctl;
    logic        w_gen;
    logic [31:0] w_gen_word, w_head, w_tail, w_t, w_rk;
    logic        w_dec;

    // key expansion uses sliding window r_w1..r_w3 plus the word four back,
    // k[i-4]; keep it in r_w4, the end of a small shift line
    logic [31:0] r_w4;
    logic [5:0]  r_zi;

    simon_key_chain u_chain (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_gen      (w_gen),
        .i_gen_word (w_gen_word),
        .o_head     (w_head),
        .o_tail     (w_tail)
    );

    always_comb begin
        w_t        = rotr32(r_w1, 3) ^ r_w3;
        w_t        = w_t ^ rotr32(w_t, 1);
        w_gen_word = (r_cnt < (RND_W+1)'(SEED_WORDS)) ?
                     ((r_cnt[1:0] == 2'd0) ? r_key_lo[31:0] :
                      (r_cnt[1:0] == 2'd1) ? r_key_lo[63:32] :
                      (r_cnt[1:0] == 2'd2) ? r_key_hi[31:0] : r_key_hi[63:32])
                   : (SCHED_CONST ^ {31'd0, Z3_BITS[r_zi]} ^ r_w4 ^ w_t);
    end

    assign w_gen = (r_state == ST_KEYS);
    assign w_dec = (r_imode == MODE_DEC);
    assign w_ctl = '{load: 1'b0,
                     shift: (r_state == ST_RUN) && !r_align,
                     dir: w_dec};
    assign w_rk  = w_dec ? w_tail : w_head;

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = (r_state == ST_OUT);
    assign o_data_out = r_out;
    assign o_valid_bytes_out = r_vb;

    logic [3:0]  w_n;
    logic [63:0] w_mask, w_cnext;
    always_comb begin
        w_n    = (r_vb > 4'd8) ? 4'd8 : r_vb;
        w_mask = (w_n == 4'd8) ? '1 : ((64'd1 << {w_n, 3'b000}) - 64'd1);
        // big-endian increment: byte 7 least significant
        w_cnext = {r_ctr[7:0], r_ctr[15:8], r_ctr[23:16], r_ctr[31:24],
                   r_ctr[39:32], r_ctr[47:40], r_ctr[55:48], r_ctr[63:56]} + 64'd1;
        w_cnext = {w_cnext[7:0], w_cnext[15:8], w_cnext[23:16], w_cnext[31:24],
                   w_cnext[39:32], w_cnext[47:40], w_cnext[55:48], w_cnext[63:56]};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_valid) n_state = r_keys_ready ? ST_RUN : ST_KEYS;
            ST_KEYS: if (r_cnt == (RND_W+1)'(ROUND_COUNT - 1)) n_state = ST_RUN;
            ST_RUN:  if (!r_align && r_cnt == (RND_W+1)'(ROUND_COUNT - 1)) n_state = ST_OUT;
            ST_OUT:  if (i_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_mode       <= MODE_ENC;
            r_key_lo     <= '0;
            r_key_hi     <= '0;
            r_ictr       <= '0;
            r_ctr        <= '0;
            r_keys_ready <= 1'b0;
            r_cnt        <= '0;
            r_align      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MODE:   r_mode <= i_cfg_data[1:0];
                    REG_KEY_LO: begin r_key_lo <= i_cfg_data; r_keys_ready <= 1'b0; end
                    REG_KEY_HI: begin r_key_hi <= i_cfg_data; r_keys_ready <= 1'b0; end
                    REG_CTR:    r_ictr <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: if (i_valid) begin
                    r_cnt   <= '0;
                    r_align <= (r_mode == MODE_DEC);
                    if (i_restart) r_ctr <= r_ictr;
                end
                ST_KEYS: begin
                    r_cnt <= (r_cnt == (RND_W+1)'(ROUND_COUNT - 1)) ? '0 : r_cnt + 1'b1;
                    if (r_cnt == (RND_W+1)'(ROUND_COUNT - 1)) r_keys_ready <= 1'b1;
                end
                ST_RUN: begin
                    if (r_align) r_align <= 1'b0;
                    else r_cnt <= r_cnt + 1'b1;
                    if (n_state == ST_OUT && r_imode != MODE_ENC && r_imode != MODE_DEC)
                        r_ctr <= w_cnext;
                end
                ST_OUT: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_imode <= r_mode;
            r_din   <= i_data_in;
            r_vb    <= i_valid_bytes;
            if (r_mode == MODE_ENC || r_mode == MODE_DEC) begin
                r_x <= i_data_in[31:0];
                r_y <= i_data_in[63:32];
            end else begin
                r_x <= i_restart ? r_ictr[31:0]  : r_ctr[31:0];
                r_y <= i_restart ? r_ictr[63:32] : r_ctr[63:32];
            end
            r_zi <= '0;
        end
        if (r_state == ST_KEYS) begin
            r_w4 <= r_w3;
            r_w3 <= r_w2;
            r_w2 <= r_w1;
            r_w1 <= w_gen_word;
            if (r_cnt >= (RND_W+1)'(SEED_WORDS))
                r_zi <= (r_zi == 6'd61) ? 6'd0 : r_zi + 6'd1;
        end
        if (r_state == ST_RUN && !r_align) begin
            if (w_dec) begin
                r_y <= r_x ^ mix(r_y) ^ w_rk;
                r_x <= r_y;
            end else begin
                r_x <= r_y ^ mix(r_x) ^ w_rk;
                r_y <= r_x;
            end
        end
        if (r_state == ST_RUN && n_state == ST_OUT) begin
            if (w_dec)
                r_out <= {r_x ^ mix(r_y) ^ w_rk, r_y};
            else if (r_imode == MODE_ENC)
                r_out <= {r_x, r_y ^ mix(r_x) ^ w_rk};
            else
                r_out <= (r_din ^ {r_x, r_y ^ mix(r_x) ^ w_rk}) & w_mask;
        end
    end
endmodule

// ----- sv/simon_checker.sv -----
// ---------------------------------------------------------------------------
// simon_checker
// Port-level checks for the SIMON engine, bound to the top level.
// ---------------------------------------------------------------------------
module simon_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_data_out
);
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready and valid together");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data_out)) else $error("result dropped");
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> !o_valid) else $error("result repeated");
endmodule

bind simon64_128_block_cipher_modes simon_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_data_out(o_data_out)
);
